// ===== src/fiber_local_slot_store_assert.svh =====
// Assertion macros used by the block's checker file
`ifndef FIBER_LOCAL_SLOT_STORE_ASSERT_SVH
`define FIBER_LOCAL_SLOT_STORE_ASSERT_SVH

// same-cycle implication, clocked and reset-gated
`define FLSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flss assertion failed");

// next-cycle implication
`define FLSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flss assertion failed");

// fixed-delay implication of cons after ante
`define FLSS_ASSERT_DLY4(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##4 (cons)) \
    else $error("flss assertion failed");

`endif

// ===== src/flss_pkg.sv =====
// Shared types and constants of the slot store
package flss_pkg;

  localparam int SLOT_COUNT_DEF    = 128;
  localparam int CONTEXT_COUNT_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int CTX_FW  = 4;
  localparam int SLOT_FW = 8;
  localparam int GRANT_W = 7;
  localparam int VAL_W   = 64;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [CTX_FW-1:0]         context_req;
    logic [SLOT_FW-1:0]        slot_index;
    logic signed [VAL_W-1:0]   write_value;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic [GRANT_W-1:0]        granted_slot;
    logic signed [VAL_W-1:0]   read_value;
  } rsp_t;

  // controller -> datapath step commands
  typedef struct packed {
    logic load;
    logic rd;
    logic scan;
    logic exec;
  } ctrl_t;

endpackage

// ===== src/fiber_local_slot_store.sv =====
// Steps: read, scan, execute and output; the result register and out_valid are loaded at the
//   end of the execute step, and out_valid then strobes the result in the output step.
// Busy: one command at a time, taken only while idle; busy covers read of the bitmap and value
//   memories, the registered free-slot search and the write-back step.
// Reset: synchronous active low; clears sequencer and per-context bitmap valid bits, so
//   every slot reads free right away. Value memory is not cleared.
module fiber_local_slot_store import flss_pkg::*; #(
  parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int CONTEXT_COUNT = CONTEXT_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  ctrl_t ctl;

  flss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  flss_dp #(
    .SLOT_COUNT    (SLOT_COUNT),
    .CONTEXT_COUNT (CONTEXT_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

// ===== src/flss_ctrl.sv =====
// Command sequencer of the slot store
module flss_ctrl import flss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output logic  out_valid,
  output ctrl_t ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_SCAN;
      S_SCAN: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    ctl.load = (state_r == S_IDLE) && start;
    ctl.rd   = (state_r == S_READ);
    ctl.scan = (state_r == S_SCAN);
    ctl.exec = (state_r == S_EXEC);
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== src/flss_dp.sv =====
// Datapath: bitmap memory, value memory, free-slot search and result register
module flss_dp import flss_pkg::*; #(
  parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int CONTEXT_COUNT = CONTEXT_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  ctrl_t ctl,
  input  req_t  in_req,
  output rsp_t  out_rsp
);

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int CTX_W     = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
  localparam int VAL_DEPTH = CONTEXT_COUNT * SLOT_COUNT;
  localparam int VAL_AW    = (VAL_DEPTH > 1) ? $clog2(VAL_DEPTH) : 1;
  localparam int CHUNK_W   = 32;
  localparam int POS_W     = $clog2(CHUNK_W);
  localparam int N_CHUNK   = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
  localparam int CSEL_W    = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
  localparam int IDX_W     = CSEL_W + POS_W;
  localparam int PAD_W     = N_CHUNK * CHUNK_W;

  // storage
  logic [SLOT_COUNT-1:0] map_mem [CONTEXT_COUNT];
  logic [VAL_W-1:0]      val_mem [VAL_DEPTH];
  logic                  row_vld_r [CONTEXT_COUNT];

  req_t                  req_r;
  logic [SLOT_COUNT-1:0] map_q_r;
  logic                  rowv_r;
  logic [VAL_W-1:0]      val_q_r;
  logic [N_CHUNK-1:0]    chunk_has_r;
  logic [POS_W-1:0]      chunk_pos_r [N_CHUNK];
  rsp_t                  rsp_r;

  logic [CTX_W+CTX_FW-1:0]   ctx_ext;
  logic [SLOT_W+SLOT_FW-1:0] slot_ext;
  logic [CTX_W-1:0]          ctx_idx;
  logic [SLOT_W-1:0]         slot_idx;
  logic [VAL_AW-1:0]         rd_addr;
  logic                      ctx_ok;
  logic                      slot_ok;
  logic [SLOT_COUNT-1:0]     row;

  assign ctx_ext  = {{CTX_W{1'b0}}, req_r.context_req};
  assign slot_ext = {{SLOT_W{1'b0}}, req_r.slot_index};
  assign ctx_idx  = ctx_ext[CTX_W-1:0];
  assign slot_idx = slot_ext[SLOT_W-1:0];
  assign ctx_ok   = ({5'd0, req_r.context_req} < 9'(CONTEXT_COUNT));
  assign slot_ok  = ({1'b0, req_r.slot_index} < 9'(SLOT_COUNT));
  assign rd_addr  = VAL_AW'(VAL_AW'(ctx_idx) * VAL_AW'(SLOT_COUNT) + VAL_AW'(slot_idx));
  // an unwritten bitmap row reads as all free
  assign row      = rowv_r ? map_q_r : '0;

  // per-chunk lowest free slot
  logic [PAD_W-1:0]         pad_row;
  logic [N_CHUNK-1:0]       chunk_has;
  logic [POS_W-1:0]         chunk_pos [N_CHUNK];

  always_comb begin
    logic [CHUNK_W-1:0] inv;
    logic [CHUNK_W-1:0] iso;
    pad_row = '1;
    pad_row[SLOT_COUNT-1:0] = row;
    for (int c = 0; c < N_CHUNK; c++) begin
      inv = ~pad_row[c*CHUNK_W +: CHUNK_W];
      iso = inv & (~inv + CHUNK_W'(1));
      chunk_has[c] = |inv;
      chunk_pos[c] = '0;
      for (int j = 0; j < CHUNK_W; j++) begin
        chunk_pos[c] = chunk_pos[c] | ({POS_W{iso[j]}} & POS_W'(j));
      end
    end
  end

  // execute step: pick chunk, decide, form writes and result
  logic [CSEL_W-1:0]        sel;
  logic [IDX_W-1:0]         alloc_wide;
  logic [SLOT_W+IDX_W-1:0]  alloc_ext;
  logic [GRANT_W+IDX_W-1:0] grant_ext;
  logic [SLOT_W-1:0]        alloc_idx;
  logic                     any_free;
  logic                     used;
  logic                     map_we;
  logic [SLOT_COUNT-1:0]    map_wd;
  logic                     val_we;
  logic [VAL_AW-1:0]        val_wa;
  logic [VAL_W-1:0]         val_wd;
  rsp_t                     rsp_nxt;

  always_comb begin
    sel = '0;
    for (int i = N_CHUNK - 1; i >= 0; i--) begin
      if (chunk_has_r[i]) begin
        sel = CSEL_W'(i);
      end
    end
    alloc_wide = {sel, chunk_pos_r[sel]};
    alloc_ext  = {{SLOT_W{1'b0}}, alloc_wide};
    grant_ext  = {{GRANT_W{1'b0}}, alloc_wide};
    alloc_idx  = alloc_ext[SLOT_W-1:0];
    any_free   = |chunk_has_r;
    used       = row[slot_idx];

    map_we  = 1'b0;
    map_wd  = row;
    val_we  = 1'b0;
    val_wa  = rd_addr;
    val_wd  = req_r.write_value;
    rsp_nxt = '0;

    if (ctx_ok) begin
      if (req_r.cmd == CMD_ALLOC) begin
        if (any_free) begin
          map_we = 1'b1;
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (SLOT_W'(s) == alloc_idx) begin
              map_wd[s] = 1'b1;
            end
          end
          val_we = 1'b1;
          val_wa = VAL_AW'(VAL_AW'(ctx_idx) * VAL_AW'(SLOT_COUNT) + VAL_AW'(alloc_idx));
          val_wd = '0;
          rsp_nxt.ok           = 1'b1;
          rsp_nxt.granted_slot = grant_ext[GRANT_W-1:0];
        end
      end else if (slot_ok && used) begin
        rsp_nxt.ok = 1'b1;
        case (req_r.cmd)
          CMD_FREE: begin
            map_we = 1'b1;
            map_wd[slot_idx] = 1'b0;
          end
          CMD_GET: rsp_nxt.read_value = val_q_r;
          CMD_SET: val_we = 1'b1;
          default: rsp_nxt.ok = 1'b1;
        endcase
      end
    end
  end

  // memories and payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_r <= in_req;
    end
    if (ctl.rd) begin
      map_q_r <= map_mem[ctx_idx];
      rowv_r  <= row_vld_r[ctx_idx];
      val_q_r <= val_mem[rd_addr];
    end
    if (ctl.scan) begin
      chunk_has_r <= chunk_has;
      for (int c = 0; c < N_CHUNK; c++) begin
        chunk_pos_r[c] <= chunk_pos[c];
      end
    end
    if (ctl.exec) begin
      rsp_r <= rsp_nxt;
      if (map_we) begin
        map_mem[ctx_idx] <= map_wd;
      end
      if (val_we) begin
        val_mem[val_wa] <= val_wd;
      end
    end
  end

  // row valid bits: cleared by reset, set on first write of a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CONTEXT_COUNT; k++) begin
        row_vld_r[k] <= 1'b0;
      end
    end else if (ctl.exec && map_we) begin
      row_vld_r[ctx_idx] <= 1'b1;
    end
  end

  assign out_rsp = rsp_r;

endmodule

// ===== src/flss_checker.sv =====
// Port-level checker of the slot store and its bind
`include "fiber_local_slot_store_assert.svh"

module flss_checker import flss_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input rsp_t out_rsp
);

  `FLSS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `FLSS_ASSERT_DLY4(a_latency, clk, rst_n, start && !busy, out_valid)
  `FLSS_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `FLSS_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `FLSS_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_rsp.ok,
                   (out_rsp.granted_slot == '0) && (out_rsp.read_value == '0))

endmodule

bind fiber_local_slot_store flss_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
